// File: hw/rtl/hafd_pkg.sv
package hafd_pkg;

  localparam int MAX_BYTES_DEF = 255;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPERA = 8'h41;
  localparam logic [7:0] CHAR_UPPERF = 8'h46;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;

  localparam logic       KIND_BYTE    = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [1:0] POS_HDR_HI  = 2'd0;
  localparam logic [1:0] POS_HDR_LO  = 2'd1;
  localparam logic [1:0] POS_PAYLOAD = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nib;
    logic       is_cr;
    logic       is_lf;
  } cls_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic [1:0] frame_status;
    logic       length_matches;
    logic       last;
  } res_t;

endpackage

// File: hw/rtl/hafd_fifo.sv
module hafd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/hafd_front.sv
module hafd_front (
  input  logic           [7:0] rx_char,
  output hafd_pkg::cls_t       cls
);

  import hafd_pkg::*;

  logic is_digit;
  logic is_letter;
  logic [7:0] digit_off;
  logic [7:0] letter_off;

  assign is_digit   = (rx_char >= CHAR_ZERO) && (rx_char <= CHAR_NINE);
  assign is_letter  = (rx_char >= CHAR_UPPERA) && (rx_char <= CHAR_UPPERF);
  assign digit_off  = rx_char - CHAR_ZERO;
  assign letter_off = rx_char - CHAR_UPPERA + 8'd10;

  always_comb begin
    cls.is_hex = is_digit || is_letter;
    cls.is_cr  = (rx_char == CHAR_CR);
    cls.is_lf  = (rx_char == CHAR_LF);
    if (is_digit) begin
      cls.nib = digit_off[3:0];
    end else if (is_letter) begin
      cls.nib = letter_off[3:0];
    end else begin
      cls.nib = 4'd0;
    end
  end

endmodule

// File: hw/rtl/hafd_back.sv
module hafd_back #(
  parameter int MAX_BYTES = hafd_pkg::MAX_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hafd_pkg::cls_t in_cls,
  output logic           in_pop,
  input  logic           out_full,
  output logic           out_push,
  output hafd_pkg::res_t out_res
);

  import hafd_pkg::*;

  localparam logic [7:0] MAX_CNT = 8'(MAX_BYTES);

  logic [1:0] char_position, char_position_next;
  logic [7:0] declared_length, declared_length_next;
  logic       header_valid, header_valid_next;
  logic [3:0] pending_nibble, pending_nibble_next;
  logic       nibble_held, nibble_held_next;
  logic [8:0] payload_chars, payload_chars_next;
  logic [7:0] decoded_count, decoded_count_next;
  logic       overflowed, overflowed_next;
  logic       frame_ended, frame_ended_next;

  logic take;
  res_t summary;

  assign take   = in_valid && !out_full;
  assign in_pop = take;

  always_comb begin
    summary = '0;
    summary.result_kind    = KIND_SUMMARY;
    summary.byte_count     = decoded_count;
    summary.last           = 1'b1;
    summary.length_matches = header_valid && ({declared_length, 1'b0} == payload_chars);
    if (overflowed) begin
      summary.frame_status = STATUS_OVERFLOW;
    end else if (decoded_count == 8'd0) begin
      summary.frame_status = STATUS_EMPTY;
    end else begin
      summary.frame_status = STATUS_OK;
    end
  end

  always_comb begin
    char_position_next   = char_position;
    declared_length_next = declared_length;
    header_valid_next    = header_valid;
    pending_nibble_next  = pending_nibble;
    nibble_held_next     = nibble_held;
    payload_chars_next   = payload_chars;
    decoded_count_next   = decoded_count;
    overflowed_next      = overflowed;
    frame_ended_next     = frame_ended;
    out_push             = 1'b0;
    out_res              = summary;
    if (take) begin
      if (in_cls.is_lf) begin
        out_push             = !frame_ended;
        char_position_next   = POS_HDR_HI;
        declared_length_next = 8'd0;
        header_valid_next    = 1'b1;
        pending_nibble_next  = 4'd0;
        nibble_held_next     = 1'b0;
        payload_chars_next   = 9'd0;
        decoded_count_next   = 8'd0;
        overflowed_next      = 1'b0;
        frame_ended_next     = 1'b0;
      end else if (frame_ended) begin
        out_push = 1'b0;
      end else if (char_position != POS_PAYLOAD) begin
        if (!in_cls.is_hex) begin
          header_valid_next = 1'b0;
        end
        declared_length_next = {declared_length[3:0], in_cls.nib};
        char_position_next   = char_position + 2'd1;
      end else if (in_cls.is_cr || !in_cls.is_hex) begin
        out_push         = 1'b1;
        frame_ended_next = 1'b1;
      end else begin
        if (payload_chars != 9'h1ff) begin
          payload_chars_next = payload_chars + 9'd1;
        end
        if (!nibble_held) begin
          pending_nibble_next = in_cls.nib;
          nibble_held_next    = 1'b1;
        end else begin
          nibble_held_next = 1'b0;
          if (decoded_count >= MAX_CNT) begin
            overflowed_next = 1'b1;
          end else begin
            decoded_count_next = decoded_count + 8'd1;
            out_push           = 1'b1;
            out_res            = '0;
            out_res.result_kind = KIND_BYTE;
            out_res.data_byte   = {pending_nibble, in_cls.nib};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position   <= POS_HDR_HI;
      declared_length <= 8'd0;
      header_valid    <= 1'b1;
      pending_nibble  <= 4'd0;
      nibble_held     <= 1'b0;
      payload_chars   <= 9'd0;
      decoded_count   <= 8'd0;
      overflowed      <= 1'b0;
      frame_ended     <= 1'b0;
    end else begin
      char_position   <= char_position_next;
      declared_length <= declared_length_next;
      header_valid    <= header_valid_next;
      pending_nibble  <= pending_nibble_next;
      nibble_held     <= nibble_held_next;
      payload_chars   <= payload_chars_next;
      decoded_count   <= decoded_count_next;
      overflowed      <= overflowed_next;
      frame_ended     <= frame_ended_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !out_push)
    else $error("result written into a full queue");

  a_lf_rearms: assert property (@(posedge clk) disable iff (rst)
    (take && in_cls.is_lf) |=> (char_position == POS_HDR_HI && !frame_ended
                               && decoded_count == 8'd0 && !overflowed))
    else $error("line feed did not rearm the frame state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> (decoded_count == MAX_CNT))
    else $error("overflow flagged below the byte limit");

  a_ended_silent: assert property (@(posedge clk) disable iff (rst)
    (frame_ended && !(take && in_cls.is_lf)) |-> !out_push)
    else $error("result produced after the frame ended");
`endif

endmodule

// File: hw/rtl/hex_ascii_frame_decoder_top.sv
// Decoder for length-prefixed ASCII hex reader replies. Characters are pushed one per clock
// while full is low; the block accepts a new character every cycle at a sustained rate of one
// character per cycle while the result queue has room. A result passes two queues: the
// character is written into the classification queue, and when it is popped the frame state
// update writes its result into the result queue at the same edge. Each payload hex pair
// within MAX_BYTES yields a byte result (result_kind 0), and CR, LF or a non-hex payload
// character yields one end-of-frame result (result_kind 1, last 1) carrying the byte count,
// the status (ok, no bytes, overflow) and whether twice the two-character header length
// matches the payload hex character count. After CR or a non-hex character, input is
// discarded until LF; LF always rearms the decoder. Both sides are two-entry queues, so a
// stalled pop does not stop the input until the queues fill. No clearing pass is needed after
// reset.
module hex_ascii_frame_decoder_top #(
  parameter int MAX_BYTES = hafd_pkg::MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_char,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind,
  output logic [7:0] data_byte,
  output logic [7:0] byte_count,
  output logic [1:0] frame_status,
  output logic       length_matches,
  output logic       last
);

  import hafd_pkg::*;

  cls_t cls_in;
  cls_t cls_q;
  logic cls_empty;
  logic cls_pop;
  res_t res_in;
  res_t res_q;
  logic res_full;
  logic res_push;

  hafd_front u_front (
    .rx_char (rx_char),
    .cls     (cls_in)
  );

  hafd_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_in),
    .full  (full),
    .pop   (cls_pop),
    .empty (cls_empty),
    .rdata (cls_q)
  );

  hafd_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!cls_empty),
    .in_cls   (cls_q),
    .in_pop   (cls_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_res  (res_in)
  );

  hafd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .rdata (res_q)
  );

  assign result_kind    = res_q.result_kind;
  assign data_byte      = res_q.data_byte;
  assign byte_count     = res_q.byte_count;
  assign frame_status   = res_q.frame_status;
  assign length_matches = res_q.length_matches;
  assign last           = res_q.last;

endmodule

// File: tb/sv/tb_hex_ascii_frame_decoder_top.sv
`timescale 1ns / 1ps

module tb_hex_ascii_frame_decoder_top;
  import hafd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] rx_char;
  logic       empty;
  logic       pop;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_count;
  logic [1:0] frame_status;
  logic       length_matches;
  logic       last;

  hex_ascii_frame_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .rx_char       (rx_char),
    .empty         (empty),
    .pop           (pop),
    .result_kind   (result_kind),
    .data_byte     (data_byte),
    .byte_count    (byte_count),
    .frame_status  (frame_status),
    .length_matches(length_matches),
    .last          (last)
  );

  class frame_tracker;
    int unsigned max_bytes;
    logic [1:0]  pos;
    logic [7:0]  decl_len;
    logic        hdr_ok;
    logic [3:0]  hi_nib;
    logic        nib_held;
    logic [8:0]  hex_chars;
    logic [7:0]  nbytes;
    logic        ovf;
    logic        ended;
    res_t        due_results[$];
    int unsigned errors;

    function new(int unsigned mb);
      max_bytes = mb;
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      pos = POS_HDR_HI;
      decl_len = 8'd0;
      hdr_ok = 1'b1;
      hi_nib = 4'd0;
      nib_held = 1'b0;
      hex_chars = 9'd0;
      nbytes = 8'd0;
      ovf = 1'b0;
      ended = 1'b0;
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR %0t: %s", $realtime, msg);
    endfunction

    function void add_summary();
      res_t r;
      r.result_kind = KIND_SUMMARY;
      r.data_byte = 8'd0;
      r.byte_count = nbytes;
      if (ovf) r.frame_status = STATUS_OVERFLOW;
      else if (nbytes == 8'd0) r.frame_status = STATUS_EMPTY;
      else r.frame_status = STATUS_OK;
      r.length_matches = hdr_ok && ({decl_len, 1'b0} == hex_chars);
      r.last = 1'b1;
      due_results.push_back(r);
    endfunction

    // one accepted request: advance the frame state, queue what it yields
    function void take_char(logic [7:0] c);
      logic       is_hex;
      logic [3:0] nib;
      res_t       r;
      is_hex = 1'b1;
      nib = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) nib = 4'(c - CHAR_ZERO);
      else if (c >= CHAR_UPPERA && c <= CHAR_UPPERF) nib = 4'(c - CHAR_UPPERA + 8'd10);
      else is_hex = 1'b0;
      if (c == CHAR_LF) begin
        if (!ended) add_summary();
        rearm();
        return;
      end
      if (ended) return;
      if (pos != POS_PAYLOAD) begin
        if (!is_hex) hdr_ok = 1'b0;
        decl_len = {decl_len[3:0], nib};
        pos = pos + 2'd1;
        return;
      end
      if (c == CHAR_CR || !is_hex) begin
        add_summary();
        ended = 1'b1;
        return;
      end
      if (hex_chars < 9'd511) hex_chars = hex_chars + 9'd1;
      if (!nib_held) begin
        hi_nib = nib;
        nib_held = 1'b1;
        return;
      end
      nib_held = 1'b0;
      if (nbytes >= max_bytes) begin
        ovf = 1'b1;
        return;
      end
      nbytes = nbytes + 8'd1;
      r.result_kind = KIND_BYTE;
      r.data_byte = {hi_nib, nib};
      r.byte_count = 8'd0;
      r.frame_status = STATUS_OK;
      r.length_matches = 1'b0;
      r.last = 1'b0;
      due_results.push_back(r);
    endfunction

    function void match_output(res_t got);
      res_t exp;
      if (due_results.size() == 0) begin
        log_error($sformatf("unexpected result kind=%0d byte=%02h count=%0d",
                            got.result_kind, got.data_byte, got.byte_count));
        return;
      end
      exp = due_results.pop_front();
      if (got.result_kind !== exp.result_kind || got.data_byte !== exp.data_byte ||
          got.byte_count !== exp.byte_count || got.frame_status !== exp.frame_status ||
          got.length_matches !== exp.length_matches || got.last !== exp.last)
        log_error($sformatf({"mismatch exp kind=%0d byte=%02h count=%0d status=%0d ",
                             "match=%0d last=%0d got kind=%0d byte=%02h count=%0d ",
                             "status=%0d match=%0d last=%0d"},
                            exp.result_kind, exp.data_byte, exp.byte_count,
                            exp.frame_status, exp.length_matches, exp.last,
                            got.result_kind, got.data_byte, got.byte_count,
                            got.frame_status, got.length_matches, got.last));
    endfunction

    function void close_out();
      if (due_results.size() != 0)
        log_error($sformatf("%0d results never arrived", due_results.size()));
    endfunction
  endclass

  frame_tracker tracker = new(MAX_BYTES_DEF);

  int unsigned idle_pct;
  int unsigned stall_pct;
  int          hold_left;
  int unsigned sent;
  int unsigned quiet_cycles;
  logic [7:0]  chars[$];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver side
  initial begin
    pop = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // sampling and watchdog
  always @(posedge clk) begin
    res_t got;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      got.result_kind = result_kind;
      got.data_byte = data_byte;
      got.byte_count = byte_count;
      got.frame_status = frame_status;
      got.length_matches = length_matches;
      got.last = last;
      if (push && !full) tracker.take_char(rx_char);
      if (pop && !empty) tracker.match_output(got);
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? 8'(CHAR_ZERO + v) : 8'(CHAR_UPPERA + v - 8'd10);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    if ($urandom_range(3) == 0) return 8'($urandom_range(8'h66, 8'h61));
    do c = 8'($urandom_range(255));
    while ((c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UPPERA && c <= CHAR_UPPERF) ||
           c == CHAR_LF);
    return c;
  endfunction

  function automatic void add_header(logic [7:0] len);
    chars.push_back(hex_char(len[7:4]));
    chars.push_back(hex_char(len[3:0]));
  endfunction

  function automatic void add_hex(int n);
    repeat (n) chars.push_back(hex_char(4'($urandom_range(15))));
  endfunction

  task automatic send_char(logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    rx_char = c;
    do @(posedge clk); while (full !== 1'b0);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_chars();
    foreach (chars[i]) send_char(chars[i]);
    chars.delete();
  endtask

  task automatic drain();
    push = 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_frame();
    int kind;
    int n;
    int k;
    kind = $urandom_range(99);
    n = $urandom_range(6);
    if (kind < 60) begin
      add_header(($urandom_range(99) < 15) ? 8'($urandom_range(255)) : 8'(n));
      add_hex(2 * n);
      if ($urandom_range(99) >= 20) chars.push_back(CHAR_CR);
    end else if (kind < 70) begin
      // unpaired nibble before the end
      add_header(8'(n));
      add_hex(2 * n + 1);
      chars.push_back(CHAR_CR);
    end else if (kind < 80) begin
      // abort on a non-hex payload character, trailing junk ignored
      add_header(8'(n));
      add_hex($urandom_range(2 * n));
      chars.push_back(junk_char());
      repeat ($urandom_range(3)) chars.push_back(8'($urandom_range(255)));
    end else if (kind < 88) begin
      k = $urandom_range(1);
      add_header(8'(n));
      chars[chars.size() - 2 + k] = junk_char();
      add_hex(2 * n);
      chars.push_back(CHAR_CR);
    end else if (kind < 94) begin
      if ($urandom_range(1)) chars.push_back(hex_char(4'($urandom_range(15))));
    end else begin
      repeat ($urandom_range(6, 1)) chars.push_back(8'($urandom_range(255)));
    end
    chars.push_back(CHAR_LF);
    send_chars();
  endtask

  initial begin
    int n;
    rst = 1'b1;
    push = 1'b0;
    rx_char = 8'd0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extreme bytes in a matching frame
    chars = '{8'h30, 8'h32, 8'h30, 8'h30, 8'h46, 8'h46, CHAR_CR, CHAR_LF};
    // bad header, odd nibble, lowercase abort, ignored tail up to the line feed
    chars = {chars, 8'h47, 8'h31, 8'h39, 8'h41, 8'h46, 8'h61, 8'h3a, CHAR_CR, CHAR_LF};
    // bare line feed, line feed inside the header, empty payload
    chars = {chars, CHAR_LF, 8'h30, CHAR_LF, 8'h30, 8'h30, CHAR_CR, CHAR_LF};
    send_chars();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      if (phase == 0) begin
        // long payload past the byte limit
        n = $urandom_range(262, 257);
        add_header(8'(n));
        add_hex(2 * n);
        chars.push_back(CHAR_CR);
        chars.push_back(CHAR_LF);
        send_chars();
        hold_left = HOLD_CYCLES;
      end
      while (sent < 700 + 130 * phase) random_frame();
      drain();
    end

    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hafd_pkg.sv
hw/rtl/hafd_fifo.sv
hw/rtl/hafd_front.sv
hw/rtl/hafd_back.sv
hw/rtl/hex_ascii_frame_decoder_top.sv
tb/sv/tb_hex_ascii_frame_decoder_top.sv
